>>> src/dmma_pkg.sv
// Shared constants, types and helpers of the matrix multiply-accumulate engine.
`default_nettype none
package dmma_pkg;

  localparam int MAX_DIM = 64;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AB_W    = 32;
  localparam int C_W     = 64;

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_LOAD_C  = 2'd2,
    MODE_COMPUTE = 2'd3
  } mode_t;

  localparam logic REG_DIM = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WAIT  = 4'b0010,
    S_ISSUE = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic lastk;
  } mac_ctl_t;

  function automatic logic [C_W-1:0] sat_add(input logic [C_W-1:0] a,
                                             input logic [C_W-1:0] b);
    logic [C_W-1:0] s;
    s = a + b;
    if ((a[C_W-1] == b[C_W-1]) && (s[C_W-1] != a[C_W-1])) begin
      s = a[C_W-1] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> src/dmma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/dmma_mac.sv
// Two-stage multiply and saturating accumulate datapath fed by the store reads.
`default_nettype none
module dmma_mac (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dmma_pkg::mac_ctl_t       issue,
  input  wire logic [dmma_pkg::AB_W-1:0] a_rdata,
  input  wire logic [dmma_pkg::AB_W-1:0] b_rdata,
  input  wire logic [dmma_pkg::C_W-1:0]  c_rdata,
  output logic                          res_vld,
  output logic      [dmma_pkg::C_W-1:0]  res_value
);
  import dmma_pkg::*;

  mac_ctl_t            s1_r, s2_r;
  logic signed [AB_W-1:0] a_s, b_s;
  logic signed [C_W-1:0]  prod_nxt;
  logic [C_W-1:0]      prod_r, cinit_r, acc_r, base, sum;

  assign a_s      = $signed(a_rdata);
  assign b_s      = $signed(b_rdata);
  assign prod_nxt = a_s * b_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r.vld) begin
      prod_r  <= prod_nxt;
      cinit_r <= c_rdata;
    end
    if (s2_r.vld) begin
      acc_r <= sum;
    end
  end

  assign base      = s2_r.first ? cinit_r : acc_r;
  assign sum       = sat_add(base, prod_r);
  assign res_vld   = s2_r.vld && s2_r.lastk;
  assign res_value = sum;

endmodule
`default_nettype wire

>>> src/dense_matrix_multiply_accumulate_top.sv
// Top level of the dense matrix multiply-accumulate engine.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_ready  | in_mode, in_row, in_col, in_value, in_c_value
//  out      | out_valid/out_ready| out_row, out_col, out_value, out_last
//  config   | psel/penable/pready| paddr, pwrite, pwdata, prdata (dim at 0x0)
//
// A compute transaction emits dim results, one per column. Each column passes through
// S_WAIT, dim issue steps of one MAC fed by one read port per store and the pipeline
// drain in S_DRAIN. A column starts only once the output register is empty; a stalled
// output holds the engine. Reset is synchronous; stores keep no reset state.
`default_nettype none
module dense_matrix_multiply_accumulate_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_mode,
  input  wire logic [dmma_pkg::IDX_W-1:0] in_row,
  input  wire logic [dmma_pkg::IDX_W-1:0] in_col,
  input  wire logic signed [31:0]        in_value,
  input  wire logic signed [63:0]        in_c_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [dmma_pkg::IDX_W-1:0] out_row,
  output logic      [dmma_pkg::IDX_W-1:0] out_col,
  output logic signed [63:0]             out_value,
  output logic                           out_last,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import dmma_pkg::*;

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   dim_r, eff_dim;
  logic [IDX_W-1:0]   dlast, row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  logic               out_vld_r, out_vld_nxt, out_last_r;
  logic [IDX_W-1:0]   out_row_r, out_col_r;
  logic [C_W-1:0]     out_value_r;
  logic               in_acc, load_ok, row_ok, wb;
  logic               a_we, b_we, c_we;
  logic [ADDR_W-1:0]  ld_addr, a_raddr, b_raddr, c_raddr, c_waddr;
  logic [C_W-1:0]     c_wdata, c_rdata;
  logic [AB_W-1:0]    a_rdata, b_rdata;
  mac_ctl_t           issue;
  logic               res_vld;
  logic [C_W-1:0]     res_value;

  // config
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIM) ? {{(32-DIM_W){1'b0}}, dim_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_W'(MAX_DIM);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIM)) begin
      dim_r <= pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    eff_dim = dim_r;
    if (dim_r == '0) begin
      eff_dim = DIM_W'(1);
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end
  end
  assign dlast = IDX_W'(eff_dim - DIM_W'(1));

  // input decode
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign row_ok   = ({1'b0, in_row} < eff_dim);
  assign load_ok  = in_acc && row_ok && ({1'b0, in_col} < eff_dim);
  assign ld_addr  = {in_row, in_col};
  assign a_we     = load_ok && (in_mode == MODE_LOAD_A);
  assign b_we     = load_ok && (in_mode == MODE_LOAD_B);
  assign wb       = res_vld;
  assign c_we     = (load_ok && (in_mode == MODE_LOAD_C)) || wb;
  assign c_waddr  = wb ? {row_r, col_r} : ld_addr;
  assign c_wdata  = wb ? res_value : in_c_value;

  assign a_raddr = {row_r, k_r};
  assign b_raddr = {k_r, col_r};
  assign c_raddr = {row_r, col_r};

  assign issue.vld   = (state_r == S_ISSUE);
  assign issue.first = (k_r == '0);
  assign issue.lastk = (k_r == dlast);

  dmma_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(ld_addr), .wdata(in_value),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  dmma_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(ld_addr), .wdata(in_value),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  dmma_ram #(.WIDTH(C_W), .DEPTH(DEPTH)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  dmma_mac u_mac (
    .clk(clk), .rst_n(rst_n), .issue(issue),
    .a_rdata(a_rdata), .b_rdata(b_rdata), .c_rdata(c_rdata),
    .res_vld(res_vld), .res_value(res_value)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_COMPUTE) && row_ok) begin
          row_nxt   = in_row;
          col_nxt   = '0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_vld_r) begin
          k_nxt     = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        k_nxt = k_r + IDX_W'(1);
        if (k_r == dlast) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res_vld) begin
          if (col_r == dlast) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt   = col_r + IDX_W'(1);
            state_nxt = S_WAIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    row_r <= row_nxt;
    col_r <= col_nxt;
    k_r   <= k_nxt;
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
    if (res_vld) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_value_r <= res_value;
      out_last_r  <= (col_r == dlast);
    end
  end

  assign out_valid = out_vld_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_wb_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    wb |-> (state_r == S_DRAIN))
    else $error("C write-back outside drain");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !out_vld_r)
    else $error("result overwrites pending output");

  a_issue_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE && k_r == dlast) |=> (state_r == S_DRAIN))
    else $error("last inner step did not enter drain");

endmodule
`default_nettype wire

>>> tb/dense_matrix_multiply_accumulate_top_tb.sv
// Self-checking testbench of the dense matrix multiply-accumulate engine.
`default_nettype none
module dense_matrix_multiply_accumulate_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmma_pkg::*;

  localparam int LIMIT         = 1_000_000;
  localparam int HOLD_LEN      = 600;
  localparam int PRIME_MAX_DIM = 8;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [C_W-1:0]   value;
    logic             last;
  } c_elem_t;

  class gemm_scoreboard;
    logic [AB_W-1:0] a_mem [DEPTH];
    logic [AB_W-1:0] b_mem [DEPTH];
    logic [C_W-1:0]  c_mem [DEPTH];
    bit              a_ok  [DEPTH];
    bit              b_ok  [DEPTH];
    bit              c_ok  [DEPTH];
    logic [6:0]      dim_reg;
    c_elem_t         due_elems [$];
    int              errors;

    function new();
      dim_reg = 7'd64;
      errors  = 0;
    endfunction

    function int active_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > MAX_DIM) return MAX_DIM;
      return dim_reg;
    endfunction

    function logic [C_W-1:0] sum_clamped(logic [C_W-1:0] x, logic [C_W-1:0] y);
      logic [C_W:0] s;
      s = {x[C_W-1], x} + {y[C_W-1], y};
      if (s[C_W] != s[C_W-1]) begin
        return s[C_W] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
      end
      return s[C_W-1:0];
    endfunction

    // true when a compute of row r reads only written entries
    function bit row_ready(int r);
      int d;
      d = active_dim();
      for (int k = 0; k < d; k++) begin
        if (!a_ok[r*MAX_DIM+k] || !c_ok[r*MAX_DIM+k]) return 0;
        for (int j = 0; j < d; j++) begin
          if (!b_ok[k*MAX_DIM+j]) return 0;
        end
      end
      return 1;
    endfunction

    function void note_item(mode_t m, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                            logic [AB_W-1:0] v, logic [C_W-1:0] cv);
      int d;
      int idx;
      logic [C_W-1:0] acc;
      logic signed [C_W-1:0] pa, pb;
      c_elem_t e;
      d = active_dim();
      if (m != MODE_COMPUTE) begin
        if (r >= d || c >= d) return;
        idx = r * MAX_DIM + c;
        case (m)
          MODE_LOAD_A: begin
            a_mem[idx] = v;
            a_ok[idx]  = 1'b1;
          end
          MODE_LOAD_B: begin
            b_mem[idx] = v;
            b_ok[idx]  = 1'b1;
          end
          default: begin
            c_mem[idx] = cv;
            c_ok[idx]  = 1'b1;
          end
        endcase
        return;
      end
      if (r >= d) return;
      for (int j = 0; j < d; j++) begin
        acc = c_mem[r*MAX_DIM+j];
        for (int k = 0; k < d; k++) begin
          pa  = $signed(a_mem[r*MAX_DIM+k]);
          pb  = $signed(b_mem[k*MAX_DIM+j]);
          acc = sum_clamped(acc, pa * pb);
        end
        c_mem[r*MAX_DIM+j] = acc;
        e.row   = r;
        e.col   = IDX_W'(j);
        e.value = acc;
        e.last  = (j == d - 1);
        due_elems.push_back(e);
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                               logic [C_W-1:0] v, logic l);
      c_elem_t e;
      if (due_elems.size() == 0) begin
        $display("%0t: result row %0d col %0d with none expected", $time, r, c);
        errors++;
        return;
      end
      e = due_elems.pop_front();
      if (r !== e.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, e.row, r);
        errors++;
      end
      if (c !== e.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, e.col, c);
        errors++;
      end
      if (v !== e.value) begin
        $display("%0t: out_value expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: out_last expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_mode;
  logic [IDX_W-1:0]        in_row;
  logic [IDX_W-1:0]        in_col;
  logic signed [31:0]      in_value;
  logic signed [63:0]      in_c_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [63:0]      out_value;
  logic                    out_last;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  gemm_scoreboard sb = new();
  int snd_idle = 34;
  int rcv_idle = 67;
  int hold_reqs = 0;

  always #5ns clk = ~clk;

  dense_matrix_multiply_accumulate_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .in_c_value (in_c_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic logic [31:0] pick_ab();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(32'h0020_0000) - 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [63:0] pick_c();
    logic [31:0] hi;
    hi = $urandom;
    case ($urandom_range(9))
      0: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(255);
      1: return 64'h8000_0000_0000_0000 + $urandom_range(255);
      2, 3: return {hi, $urandom};
      default: return {{16{hi[15]}}, hi[15:0], $urandom};
    endcase
  endfunction

  task automatic send_item(input mode_t m, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [31:0] v,
                           input logic [63:0] cv);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_row     <= r;
    in_col     <= c;
    in_value   <= v;
    in_c_value <= cv;
    do @(posedge clk); while (!in_ready);
    sb.note_item(m, r, c, v, cv);
  endtask

  // drop valid, wait for every due element, then let the engine settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_elems.size() != 0) @(posedge clk);
    repeat (sb.active_dim() + 16) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_DIM, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      sb.dim_reg = wdata[6:0];
    end else if (prdata[6:0] !== sb.dim_reg) begin
      $display("%0t: dim readback expected %0d actual %0d", $time, sb.dim_reg, prdata[6:0]);
      sb.errors++;
    end
  endtask

  // load every entry a compute of row r would read that is not yet written
  task automatic prime_row(input int r);
    int d;
    d = sb.active_dim();
    for (int k = 0; k < d; k++) begin
      if (!sb.a_ok[r*MAX_DIM+k]) send_item(MODE_LOAD_A, IDX_W'(r), IDX_W'(k), pick_ab(), pick_c());
      if (!sb.c_ok[r*MAX_DIM+k]) send_item(MODE_LOAD_C, IDX_W'(r), IDX_W'(k), pick_ab(), pick_c());
    end
    for (int k = 0; k < d; k++) begin
      for (int j = 0; j < d; j++) begin
        if (!sb.b_ok[k*MAX_DIM+j]) begin
          send_item(MODE_LOAD_B, IDX_W'(k), IDX_W'(j), pick_ab(), pick_c());
        end
      end
    end
  endtask

  task automatic run_phase(input logic [6:0] dim_set, input int budget,
                           input int s_idle, input int r_idle, input bit hold);
    int d;
    int r;
    int sel;
    wait_drained();
    apb_xfer(1'b1, {25'($urandom), dim_set});
    apb_xfer(1'b0, 32'd0);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    if (hold) hold_reqs++;
    for (int n = 0; n < budget; n++) begin
      d   = sb.active_dim();
      r   = $urandom_range(d - 1);
      sel = $urandom_range(19);
      if (sel >= 17 && d < MAX_DIM) begin
        send_item(MODE_COMPUTE, IDX_W'($urandom_range(MAX_DIM - 1, d)), IDX_W'($urandom),
                  pick_ab(), pick_c());
      end else if (sel >= 15 && d < MAX_DIM) begin
        if ($urandom_range(1)) begin
          send_item(mode_t'($urandom_range(2)), IDX_W'($urandom_range(MAX_DIM - 1, d)),
                    IDX_W'($urandom), pick_ab(), pick_c());
        end else begin
          send_item(mode_t'($urandom_range(2)), IDX_W'(r),
                    IDX_W'($urandom_range(MAX_DIM - 1, d)), pick_ab(), pick_c());
        end
      end else if (sel == 19) begin
        wait_drained();
      end else if (sel >= 9 || (d > PRIME_MAX_DIM && !sb.row_ready(r))) begin
        send_item(mode_t'($urandom_range(2)), IDX_W'(r), IDX_W'($urandom_range(d - 1)),
                  pick_ab(), pick_c());
      end else begin
        if (!sb.row_ready(r)) prime_row(r);
        send_item(MODE_COMPUTE, IDX_W'(r), IDX_W'($urandom), pick_ab(), pick_c());
      end
    end
  endtask

  // result side: random stalls plus a long hold-off on request
  initial begin : rx_side
    int stall_left;
    int holds_seen;
    out_ready  = 1'b0;
    stall_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_row, out_col, out_value, out_last);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_LOAD_A;
    in_row     = '0;
    in_col     = '0;
    in_value   = '0;
    in_c_value = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of dim, then a 2x2 directed pass
    apb_xfer(1'b0, 32'd0);
    apb_xfer(1'b1, 32'd2);
    send_item(MODE_LOAD_A, 6'd0, 6'd0, 32'h7FFF_FFFF, pick_c());
    send_item(MODE_LOAD_A, 6'd0, 6'd1, 32'h8000_0000, pick_c());
    send_item(MODE_LOAD_B, 6'd0, 6'd0, 32'h7FFF_FFFF, pick_c());
    send_item(MODE_LOAD_B, 6'd1, 6'd0, 32'h8000_0000, pick_c());
    send_item(MODE_LOAD_B, 6'd0, 6'd1, 32'h8000_0000, pick_c());
    send_item(MODE_LOAD_B, 6'd1, 6'd1, 32'h7FFF_FFFF, pick_c());
    send_item(MODE_LOAD_C, 6'd0, 6'd0, pick_ab(), 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(MODE_LOAD_C, 6'd0, 6'd1, pick_ab(), 64'h8000_0000_0000_0000);
    // loads outside the matrix must not land
    send_item(MODE_LOAD_A, 6'd63, 6'd0, 32'h0, pick_c());
    send_item(MODE_LOAD_B, 6'd0, 6'd63, 32'h0, pick_c());
    send_item(MODE_LOAD_C, 6'd2, 6'd1, pick_ab(), 64'd0);
    send_item(MODE_COMPUTE, 6'd0, 6'd63, pick_ab(), pick_c());
    send_item(MODE_COMPUTE, 6'd63, 6'd0, pick_ab(), pick_c());
    send_item(MODE_COMPUTE, 6'd2, 6'd0, pick_ab(), pick_c());
    send_item(MODE_LOAD_A, 6'd1, 6'd0, 32'h0001_0000, pick_c());
    send_item(MODE_LOAD_A, 6'd1, 6'd1, 32'hFFFF_0000, pick_c());
    send_item(MODE_LOAD_C, 6'd1, 6'd0, pick_ab(), 64'd0);
    send_item(MODE_LOAD_C, 6'd1, 6'd1, pick_ab(), 64'd1);
    send_item(MODE_COMPUTE, 6'd1, 6'd0, pick_ab(), pick_c());
    send_item(MODE_COMPUTE, 6'd0, 6'd0, pick_ab(), pick_c());

    run_phase(7'd3,   25, 34, 67, 1'b0);
    run_phase(7'd0,   10, 34, 67, 1'b0);
    run_phase(7'd5,   25, 34, 67, 1'b1);
    run_phase(7'd64,   6, 67, 34, 1'b0);
    run_phase(7'd4,   20, 67, 34, 1'b0);
    run_phase(7'd2,   15, 67, 34, 1'b0);
    run_phase(7'd127,  5,  0,  0, 1'b0);
    run_phase(7'd6,   25,  0,  0, 1'b0);
    run_phase(7'd1,   10,  0,  0, 1'b0);
    run_phase(7'd3,   20,  0,  0, 1'b0);

    wait_drained();
    if (sb.errors == 0 && sb.due_elems.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
